/* src/mbd_pkg.sv */
// Shared types and constants for the multi-button debouncer.
// Used by mbd_cfg, mbd_button and the top level; no dependencies.
package mbd_pkg;

  localparam int BUTTONS     = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int LIMIT_W     = 16;
  localparam int CMP_W       = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam int INDEX_W     = 3;

  localparam logic [LIMIT_W-1:0] DEBOUNCE_RST   = LIMIT_W'(50);
  localparam logic [LIMIT_W-1:0] LONG_PRESS_RST = LIMIT_W'(1000);
  localparam logic [BUTTONS-1:0] FALLING_RST    = BUTTONS'(2);
  localparam logic [BUTTONS-1:0] IDLE_RST       = {BUTTONS{1'b1}};

  typedef enum logic [INDEX_W-1:0] {
    REG_DEBOUNCE_LIMIT    = 3'd0,
    REG_LONG_PRESS_LIMIT  = 3'd1,
    REG_FALLING_EDGE_MASK = 3'd2,
    REG_IDLE_LEVEL_MASK   = 3'd3,
    REG_SCAN_ENABLE       = 3'd4,
    REG_LONG_PRESS_ENABLE = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic [LIMIT_W-1:0] long_press_limit;
    logic [BUTTONS-1:0] falling_edge_mask;
    logic [BUTTONS-1:0] idle_level_mask;
    logic               scan_enable;
    logic               long_press_enable;
  } cfg_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] debounce_limit;
    logic [LIMIT_W-1:0] long_press_limit;
    logic               falling;
    logic               idle;
    logic               long_press_enable;
  } lane_cfg_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] cnt,
                                   input logic [LIMIT_W-1:0] limit);
    reached = CMP_W'(cnt) >= CMP_W'(limit);
  endfunction

endpackage

/* src/multi_button_debounce_edge_longpress.sv */
// Multi-button debouncer with press edge events and long-press detection. Each accepted
// request is one sample tick carrying the raw level of every button; while scanning is on,
// all buttons update in parallel, and one result follows per tick. A tick can be taken every
// clock cycle: the lane logic sits between the request port and a single result register,
// and a new request is accepted whenever that register is empty or being drained.
// Depends on mbd_pkg, mbd_cfg and mbd_button.
module multi_button_debounce_edge_longpress import mbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BUTTONS-1:0] in_pin_levels,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BUTTONS-1:0] out_press_events,
  output logic [BUTTONS-1:0] out_long_press_events,
  output logic [BUTTONS-1:0] out_stable_levels
);

  cfg_t               cfg;
  logic               in_accept, step;
  logic [BUTTONS-1:0] press, longp, stable;

  logic               out_valid_r, out_valid_nxt;
  logic [BUTTONS-1:0] press_r, long_r, stable_r;

  mbd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign step      = in_accept && cfg.scan_enable;

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    lane_cfg_t lcfg;

    assign lcfg.debounce_limit    = cfg.debounce_limit;
    assign lcfg.long_press_limit  = cfg.long_press_limit;
    assign lcfg.falling           = cfg.falling_edge_mask[i];
    assign lcfg.idle              = cfg.idle_level_mask[i];
    assign lcfg.long_press_enable = cfg.long_press_enable;

    mbd_button u_button (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .raw      (in_pin_levels[i]),
      .lcfg     (lcfg),
      .press_o  (press[i]),
      .long_o   (longp[i]),
      .stable_o (stable[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      press_r  <= press;
      long_r   <= longp;
      stable_r <= stable;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_press_events      = press_r;
  assign out_long_press_events = long_r;
  assign out_stable_levels     = stable_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid)
    else $error("accepted request produced no result");

  a_quiet_when_unscanned: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && !cfg.scan_enable |=>
      out_press_events == '0 && out_long_press_events == '0)
    else $error("event reported while scanning is off");

endmodule

/* src/mbd_cfg.sv */
// Configuration register file for the multi-button debouncer.
// Depends on mbd_pkg for the register indexes and the cfg_t bundle.
module mbd_cfg import mbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output cfg_t               cfg_o
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_LIMIT:    cfg_nxt.debounce_limit    = cfg_wdata;
        REG_LONG_PRESS_LIMIT:  cfg_nxt.long_press_limit  = cfg_wdata;
        REG_FALLING_EDGE_MASK: cfg_nxt.falling_edge_mask = cfg_wdata[BUTTONS-1:0];
        REG_IDLE_LEVEL_MASK:   cfg_nxt.idle_level_mask   = cfg_wdata[BUTTONS-1:0];
        REG_SCAN_ENABLE:       cfg_nxt.scan_enable       = cfg_wdata[0];
        REG_LONG_PRESS_ENABLE: cfg_nxt.long_press_enable = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit    <= DEBOUNCE_RST;
      cfg_r.long_press_limit  <= LONG_PRESS_RST;
      cfg_r.falling_edge_mask <= FALLING_RST;
      cfg_r.idle_level_mask   <= IDLE_RST;
      cfg_r.scan_enable       <= 1'b0;
      cfg_r.long_press_enable <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

/* src/mbd_button.sv */
// One button lane: debounce counter, stable level, edge event and hold counter.
// Depends on mbd_pkg for lane_cfg_t and the saturating counter helpers.
module mbd_button import mbd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      raw,
  input  lane_cfg_t lcfg,
  output logic      press_o,
  output logic      long_o,
  output logic      stable_o
);

  logic                   stable_r, stable_nxt;
  logic                   done_r, done_nxt;
  logic [COUNT_WIDTH-1:0] db_r, db_nxt;
  logic [COUNT_WIDTH-1:0] hold_r, hold_nxt;

  logic                   diff, db_hit, is_press, rearm, hold_run, hold_hit;
  logic [COUNT_WIDTH-1:0] db_inc, hold_mid, hold_inc;
  logic                   done_mid, stable_new;

  always_comb begin
    diff       = raw != stable_r;
    db_inc     = sat_inc(db_r);
    db_hit     = diff && reached(db_inc, lcfg.debounce_limit);
    stable_new = db_hit ? raw : stable_r;
    is_press   = db_hit && (lcfg.falling ^ (raw == lcfg.idle));
    rearm      = db_hit && !is_press && lcfg.long_press_enable;
    hold_mid   = rearm ? '0 : hold_r;
    done_mid   = rearm ? 1'b0 : done_r;
    hold_run   = lcfg.long_press_enable && !done_mid && (stable_new == lcfg.idle);
    hold_inc   = sat_inc(hold_mid);
    hold_hit   = hold_run && reached(hold_inc, lcfg.long_press_limit);

    stable_nxt = stable_r;
    db_nxt     = db_r;
    hold_nxt   = hold_r;
    done_nxt   = done_r;
    if (step) begin
      stable_nxt = stable_new;
      db_nxt     = (diff && !db_hit) ? db_inc : '0;
      hold_nxt   = hold_hit ? '0 : (hold_run ? hold_inc : hold_mid);
      done_nxt   = hold_hit ? 1'b1 : done_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      done_r   <= 1'b0;
      db_r     <= '0;
      hold_r   <= '0;
    end else begin
      stable_r <= stable_nxt;
      done_r   <= done_nxt;
      db_r     <= db_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign press_o  = step && is_press;
  assign long_o   = step && hold_hit;
  assign stable_o = stable_nxt;

  a_press_moves_level: assert property (@(posedge clk) disable iff (!rst_n)
    press_o |=> stable_r != $past(stable_r))
    else $error("press event without a stable level change");

  a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(stable_r) && $stable(db_r) && $stable(hold_r) && $stable(done_r))
    else $error("lane state moved without a counted tick");

  a_long_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    long_o |=> done_r && hold_r == '0)
    else $error("long press did not disarm detection");

endmodule

/* tb/tb_multi_button_debounce_edge_longpress.sv */
// Self-checking testbench for multi_button_debounce_edge_longpress: drives button
// sample ticks and register settings, predicts every result and compares it field by field.
// Depends on mbd_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_multi_button_debounce_edge_longpress;
  import mbd_pkg::*;

  localparam int CLK_HALF        = 2;
  localparam int RESET_CYCLES    = 7;
  localparam int NUM_PHASES      = 12;
  localparam int PRESSURE_PHASE  = 3;
  localparam int PRESSURE_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 1000;

  localparam logic [INDEX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [INDEX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BUTTONS-1:0] press;
    logic [BUTTONS-1:0] longp;
    logic [BUTTONS-1:0] levels;
  } tick_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [BUTTONS-1:0] in_pin_levels = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BUTTONS-1:0] out_press_events;
  logic [BUTTONS-1:0] out_long_press_events;
  logic [BUTTONS-1:0] out_stable_levels;

  multi_button_debounce_edge_longpress DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pin_levels         (in_pin_levels),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_press_events      (out_press_events),
    .out_long_press_events (out_long_press_events),
    .out_stable_levels     (out_stable_levels)
  );

  // Register mirror and per-button state of the debouncer
  logic [LIMIT_W-1:0]     db_lim;
  logic [LIMIT_W-1:0]     lp_lim;
  logic [BUTTONS-1:0]     fall_m;
  logic [BUTTONS-1:0]     idle_m;
  logic                   scan_on;
  logic                   lp_on;
  logic [BUTTONS-1:0]     settled;
  logic [COUNT_WIDTH-1:0] bounce_cnt [BUTTONS];
  logic [COUNT_WIDTH-1:0] hold_cnt [BUTTONS];
  logic [BUTTONS-1:0]     long_reported;

  logic [BUTTONS-1:0] tick_queue [$];
  tick_result_t       expected_results [$];

  int  errors = 0;
  int  ticks_checked = 0;
  int  press_seen = 0;
  int  long_seen = 0;
  int  settings_used = 0;
  int  phase_id = -1;
  bit  idle_on = 1'b1;
  bit  pressure_done = 1'b0;
  int  send_gap = 0;
  int  ready_hold = 0;
  int  quiet_cycles = 0;

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic tick_result_t debounce_tick(input logic [BUTTONS-1:0] pins);
    tick_result_t r;
    logic         at_idle;
    r = '0;
    if (scan_on) begin
      for (int b = 0; b < BUTTONS; b++) begin
        if (pins[b] != settled[b]) begin
          bounce_cnt[b] = bump(bounce_cnt[b]);
          if (bounce_cnt[b] >= db_lim) begin
            settled[b]    = pins[b];
            bounce_cnt[b] = '0;
            at_idle       = (pins[b] == idle_m[b]);
            if (fall_m[b] != at_idle) begin
              r.press[b] = 1'b1;
            end else if (lp_on) begin
              long_reported[b] = 1'b0;
              hold_cnt[b]      = '0;
            end
          end
        end else begin
          bounce_cnt[b] = '0;
        end
        if (lp_on && !long_reported[b] && settled[b] == idle_m[b]) begin
          hold_cnt[b] = bump(hold_cnt[b]);
          if (hold_cnt[b] >= lp_lim) begin
            hold_cnt[b]      = '0;
            long_reported[b] = 1'b1;
            r.longp[b]       = 1'b1;
          end
        end
      end
    end
    r.levels = settled;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [BUTTONS-1:0] got,
                                 input logic [BUTTONS-1:0] want);
    $display("MISMATCH at tick %0d: %s got %h expected %h", ticks_checked, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    tick_result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no pending request", out_stable_levels, '0);
    end else begin
      want = expected_results.pop_front();
      if (out_press_events !== want.press)
        report_mismatch("press_events", out_press_events, want.press);
      if (out_long_press_events !== want.longp)
        report_mismatch("long_press_events", out_long_press_events, want.longp);
      if (out_stable_levels !== want.levels)
        report_mismatch("stable_levels", out_stable_levels, want.levels);
    end
    ticks_checked++;
    press_seen += $countones(out_press_events);
    long_seen  += $countones(out_long_press_events);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(debounce_tick(in_pin_levels));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() > 0) begin
          in_valid      <= 1'b1;
          in_pin_levels <= tick_queue.pop_front();
          if (idle_on && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        check_result();
      if (phase_id == PRESSURE_PHASE && !pressure_done) begin
        pressure_done = 1'b1;
        ready_hold    = PRESSURE_CYCLES;
        out_ready     <= 1'b0;
      end else if (ready_hold > 0) begin
        ready_hold--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        ready_hold = $urandom_range(0, 13);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("tb_multi_button_debounce_edge_longpress failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEBOUNCE_LIMIT:    db_lim  = val;
      REG_LONG_PRESS_LIMIT:  lp_lim  = val;
      REG_FALLING_EDGE_MASK: fall_m  = val[BUTTONS-1:0];
      REG_IDLE_LEVEL_MASK:   idle_m  = val[BUTTONS-1:0];
      REG_SCAN_ENABLE:       scan_on = val[0];
      REG_LONG_PRESS_ENABLE: lp_on   = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [LIMIT_W-1:0] db, input logic [LIMIT_W-1:0] lp,
                                input logic [BUTTONS-1:0] fall, input logic [BUTTONS-1:0] idle,
                                input logic scan, input logic lpe);
    write_reg(REG_DEBOUNCE_LIMIT, db);
    write_reg(REG_LONG_PRESS_LIMIT, lp);
    write_reg(REG_FALLING_EDGE_MASK, {12'($urandom), fall});
    write_reg(REG_IDLE_LEVEL_MASK, {12'($urandom), idle});
    write_reg(REG_SCAN_ENABLE, {15'($urandom), scan});
    write_reg(REG_LONG_PRESS_ENABLE, {15'($urandom), lpe});
    settings_used++;
  endtask

  task automatic wait_drained();
    while (tick_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_ticks(input logic [BUTTONS-1:0] pins []);
    foreach (pins[k]) tick_queue.push_back(pins[k]);
  endtask

  function automatic logic [LIMIT_W-1:0] pick_limit(input int cap);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LIMIT_W'(1);
      2:       return '1;
      default: return LIMIT_W'($urandom_range(2, cap));
    endcase
  endfunction

  // Hold a button pattern for a run of ticks, sometimes long enough for a long press,
  // with the odd glitch tick mixed in
  task automatic queue_ticks(input int count);
    int                 span;
    int                 hold_span;
    int                 run;
    int                 n;
    logic [BUTTONS-1:0] pattern;
    logic [BUTTONS-1:0] pins;
    n         = 0;
    span      = (db_lim > 12) ? 12 : int'(db_lim);
    hold_span = (lp_lim > 40) ? 40 : int'(lp_lim);
    while (n < count) begin
      pattern = BUTTONS'($urandom_range(0, 15));
      run     = $urandom_range(1, 2 * span + 4);
      if ($urandom_range(0, 3) == 0)
        run += $urandom_range(0, hold_span);
      for (int k = 0; k < run && n < count; k++) begin
        pins = pattern;
        if ($urandom_range(0, 9) == 0)
          pins ^= BUTTONS'($urandom_range(1, 15));
        tick_queue.push_back(pins);
        n++;
      end
    end
  endtask

  initial begin
    db_lim        = DEBOUNCE_RST;
    lp_lim        = LONG_PRESS_RST;
    fall_m        = FALLING_RST;
    idle_m        = IDLE_RST;
    scan_on       = 1'b0;
    lp_on         = 1'b1;
    settled       = '0;
    long_reported = '0;
    for (int b = 0; b < BUTTONS; b++) begin
      bounce_cnt[b] = '0;
      hold_cnt[b]   = '0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Scanning off after reset: ticks leave the state alone
    push_ticks('{4'hF, 4'h0, 4'hA});
    wait_drained();

    // Zero limits: every change and long press lands on its first tick
    apply_settings('0, '0, 4'hA, 4'h5, 1'b1, 1'b1);
    push_ticks('{4'hF, 4'hF, 4'h0, 4'h5, 4'hA, 4'hF, 4'h0, 4'h0});
    wait_drained();

    // Spare register indexes are ignored; long press off, then back on
    write_reg(IDX_SPARE_LO, '1);
    write_reg(IDX_SPARE_HI, '0);
    apply_settings(LIMIT_W'(1), LIMIT_W'(1), 4'hF, 4'h0, 1'b1, 1'b0);
    push_ticks('{4'hF, 4'h0, 4'hF, 4'hF, 4'h3});
    wait_drained();
    write_reg(REG_LONG_PRESS_ENABLE, LIMIT_W'(1));
    push_ticks('{4'h3, 4'h0, 4'h0});
    wait_drained();

    // Scanning off with levels held
    write_reg(REG_SCAN_ENABLE, '0);
    push_ticks('{4'h0, 4'hF, 4'hC});
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      idle_on = (p < NUM_PHASES - 2);
      if (p == 0)
        apply_settings(LIMIT_W'(1), LIMIT_W'(1), '0, '0, 1'b1, 1'b1);
      else if (p == 1)
        apply_settings('1, '1, '1, '1, 1'b1, 1'b1);
      else
        apply_settings(pick_limit(6), pick_limit(30), BUTTONS'($urandom_range(0, 15)),
                       BUTTONS'($urandom_range(0, 15)),
                       (p == PRESSURE_PHASE) || ($urandom_range(0, 9) != 0),
                       $urandom_range(0, 4) != 0);
      phase_id = p;
      queue_ticks((p == 1) ? 40 : 160);
      wait_drained();
    end

    $display("Run covered %0d ticks under %0d register settings.", ticks_checked,
             settings_used);
    $display("Saw %0d press events and %0d long-press events; %0d mismatches.",
             press_seen, long_seen, errors);
    if (errors == 0)
      $display("tb_multi_button_debounce_edge_longpress passed");
    else
      $display("tb_multi_button_debounce_edge_longpress failed");
    $finish;
  end

endmodule

/* filelist.f */
src/mbd_pkg.sv
src/mbd_cfg.sv
src/mbd_button.sv
src/multi_button_debounce_edge_longpress.sv
tb/tb_multi_button_debounce_edge_longpress.sv
